### rtl/core/slv3_pkg.sv
// ----------------------------------------------------------------------------
// slv3_pkg: shared types for the 3x3 Cramer's-rule solver
// Fixed data format and the packed beats of the input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package slv3_pkg;

  // Signed fixed-point format of every matrix, vector and solution element.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Width of the determinant threshold register.
  localparam int THR_WIDTH  = 31;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  // One input beat: the row-major matrix and the right-hand side.
  typedef struct packed {
    word_t a_00;
    word_t a_01;
    word_t a_02;
    word_t a_10;
    word_t a_11;
    word_t a_12;
    word_t a_20;
    word_t a_21;
    word_t a_22;
    word_t rhs_0;
    word_t rhs_1;
    word_t rhs_2;
  } problem_t;

  // One result beat.
  typedef struct packed {
    word_t sol_0;
    word_t sol_1;
    word_t sol_2;
    logic  solved;
    logic  saturated;
  } answer_t;

endpackage

`default_nettype wire

### rtl/core/solve_3x3_cramer.sv
// ----------------------------------------------------------------------------
// solve_3x3_cramer: pipelined 3x3 linear solver by Cramer's rule
// Forms the determinant and the three numerators exactly, checks the
// determinant against a threshold and divides with a bit-per-stage divider.
// ----------------------------------------------------------------------------
//
//   channel   | signals                    | handshake
//   ----------+----------------------------+------------------------------
//   input     | start, busy, problem       | beat taken when start & !busy
//   result    | done, answer               | one-cycle strobe, no stall
//   config    | cfg_we, cfg_wdata          | written when cfg_we is high
//
// A new system may enter in every cycle; busy is always low.
// Each result passes through seven arithmetic and alignment stages, then
// the restoring divider with one quotient bit per stage, which makes up
// most of the pipeline depth, and a registered output stage.
// Synchronous reset clears the valid bits and loads a threshold of 1.
// The receiver cannot stall, so the pipeline never holds.
//
`default_nettype none

module solve_3x3_cramer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire slv3_pkg::problem_t  problem,
  input  wire logic                cfg_we,
  input  wire logic [slv3_pkg::THR_WIDTH-1:0] cfg_wdata,
  output logic                     done,
  output slv3_pkg::answer_t        answer
);
  import slv3_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;          // one product of two elements
  localparam int MW = 2 * W + 1;      // one 2x2 minor
  localparam int HW = 2 * W + 1;      // one partial product of a triple term
  localparam int TW = 3 * W + 1;      // one triple product
  localparam int SW = 3 * W + 3;      // determinant or numerator
  localparam int XW = SW + F + W + 1; // divider remainder and compare width

  // Operand indexes of the nine minors: minor k = a[LA]*a[LB] - a[RA]*a[RB].
  localparam int LA [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int LB [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int RA [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int RB [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Threshold register.
  logic [THR_WIDTH-1:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_WIDTH'(1);
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // Unpack the input beat into element arrays.
  word_t av [9];
  word_t bv [3];

  always_comb begin
    av[0] = problem.a_00;
    av[1] = problem.a_01;
    av[2] = problem.a_02;
    av[3] = problem.a_10;
    av[4] = problem.a_11;
    av[5] = problem.a_12;
    av[6] = problem.a_20;
    av[7] = problem.a_21;
    av[8] = problem.a_22;
    bv[0] = problem.rhs_0;
    bv[1] = problem.rhs_1;
    bv[2] = problem.rhs_2;
  end

  // Valid bits of the arithmetic stages.
  logic v1, v2, v3, v4, v5, v6, v7;
  wire  take = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // Stage 1: the eighteen element products, plus the elements needed later.
  logic signed [PW-1:0] pl [9];
  logic signed [PW-1:0] pr [9];
  word_t                x1 [6];
  word_t                x2 [6];

  for (genvar k = 0; k < 9; k++) begin : g_prod
    always_ff @(posedge clk) begin
      pl[k] <= av[LA[k]] * av[LB[k]];
      pr[k] <= av[RA[k]] * av[RB[k]];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      x1[i]     <= av[i];
      x1[3 + i] <= bv[i];
    end
    x2 <= x1;
  end

  // Stage 2: the nine 2x2 minors.
  logic signed [MW-1:0] minor [9];

  for (genvar k = 0; k < 9; k++) begin : g_minor
    always_ff @(posedge clk) begin
      minor[k] <= MW'(pl[k]) - MW'(pr[k]);
    end
  end

  // Stage 3: each triple term split into two partial products by minor half.
  // Terms 0..2 form the determinant, terms 3g..3g+2 numerator g-1.
  logic signed [HW-1:0] plo [12];
  logic signed [HW-1:0] phi [12];

  for (genvar g = 0; g < 4; g++) begin : g_grp
    for (genvar j = 0; j < 3; j++) begin : g_term
      localparam int T  = 3 * g + j;
      localparam int XI = (g == 0) ? j : 3 + j;
      localparam int MI = (g == 0) ? j : 3 * j + g - 1;
      always_ff @(posedge clk) begin
        plo[T] <= $signed({1'b0, minor[MI][W-1:0]}) * x2[XI];
        phi[T] <= $signed(minor[MI][MW-1:W]) * x2[XI];
      end
    end
  end

  // Stage 4: recombine the partial products into full triple terms.
  logic signed [TW-1:0] term [12];

  for (genvar t = 0; t < 12; t++) begin : g_recomb
    always_ff @(posedge clk) begin
      term[t] <= (TW'(phi[t]) <<< W) + TW'(plo[t]);
    end
  end

  // Stage 5: determinant (index 0) and the three numerators.
  logic signed [SW-1:0] acc [4];

  for (genvar g = 0; g < 4; g++) begin : g_sum
    always_ff @(posedge clk) begin
      acc[g] <= SW'(term[3 * g]) + SW'(term[3 * g + 1]) + SW'(term[3 * g + 2]);
    end
  end

  // Stage 6: magnitudes, quotient signs and the threshold test.
  logic [SW-1:0] mag [4];
  logic [XW-1:0] thr_wide;
  logic [XW-1:0] dm6;
  logic [XW-1:0] nm6 [3];
  logic [2:0]    neg6;
  logic          ok6;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = acc[i][SW-1] ? (~acc[i] + SW'(1)) : acc[i];
    end
    thr_wide = XW'(thr) << (2 * F);
  end

  always_ff @(posedge clk) begin
    dm6 <= XW'(mag[0]);
    ok6 <= XW'(mag[0]) > thr_wide;
    for (int i = 0; i < 3; i++) begin
      nm6[i]  <= XW'(mag[i + 1]) << F;
      neg6[i] <= acc[i + 1][SW-1] ^ acc[0][SW-1];
    end
  end

  // Stage 7: a quotient of 2^W or more saturates for certain.
  logic [XW-1:0] drem [W+1][3];
  logic [W-1:0]  dquo [W+1][3];
  logic [XW-1:0] ddiv [W+1];
  logic [2:0]    dneg [W+1];
  logic [2:0]    dovf [W+1];
  logic          dok  [W+1];
  logic          dval [W+1];

  always_ff @(posedge clk) begin
    ddiv[0] <= dm6;
    dneg[0] <= neg6;
    dok[0]  <= ok6;
    for (int i = 0; i < 3; i++) begin
      drem[0][i] <= nm6[i];
      dquo[0][i] <= '0;
      dovf[0][i] <= nm6[i] >= (dm6 << W);
    end
  end

  assign dval[0] = v7;

  // Divider stages: stage s decides quotient bit W-1-s.
  for (genvar s = 0; s < W; s++) begin : g_div
    localparam int K = W - 1 - s;
    logic [XW-1:0] dsh;
    assign dsh = ddiv[s] << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        dval[s + 1] <= 1'b0;
      end else begin
        dval[s + 1] <= dval[s];
      end
    end

    always_ff @(posedge clk) begin
      ddiv[s + 1] <= ddiv[s];
      dneg[s + 1] <= dneg[s];
      dovf[s + 1] <= dovf[s];
      dok[s + 1]  <= dok[s];
      for (int i = 0; i < 3; i++) begin
        if (drem[s][i] >= dsh) begin
          drem[s + 1][i]    <= drem[s][i] - dsh;
          dquo[s + 1][i]    <= dquo[s][i] | (W'(1) << K);
        end else begin
          drem[s + 1][i]    <= drem[s][i];
          dquo[s + 1][i]    <= dquo[s][i];
        end
      end
    end
  end

  // Output stage: clip to range, apply the sign, zero when unsolvable.
  logic [W:0]   lim  [3];
  logic [W-1:0] mval [3];
  logic [2:0]   clip;
  word_t        sol  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i]  = dneg[W][i] ? ((W+1)'(1) << (W - 1))
                           : (((W+1)'(1) << (W - 1)) - (W+1)'(1));
      clip[i] = dovf[W][i] | ({1'b0, dquo[W][i]} > lim[i]);
      mval[i] = clip[i] ? lim[i][W-1:0] : dquo[W][i];
      sol[i]  = dneg[W][i] ? (~mval[i] + W'(1)) : mval[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dval[W];
    end
  end

  always_ff @(posedge clk) begin
    if (dok[W]) begin
      answer.sol_0     <= sol[0];
      answer.sol_1     <= sol[1];
      answer.sol_2     <= sol[2];
      answer.solved    <= 1'b1;
      answer.saturated <= |clip;
    end else begin
      answer.sol_0     <= '0;
      answer.sol_1     <= '0;
      answer.sol_2     <= '0;
      answer.solved    <= 1'b0;
      answer.saturated <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 Cramer's-rule solver
// Drives systems of equations through the input port, predicts each answer
// with exact wide-integer arithmetic and checks every result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import slv3_pkg::*;

  localparam int LATENCY   = DATA_WIDTH + 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int NUM_RANDOM = 2000;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  problem_t   problem;
  logic       cfg_we;
  logic [THR_WIDTH-1:0] cfg_wdata;
  logic       done;
  answer_t    answer;

  // Predictor copy of the threshold register.
  logic [THR_WIDTH-1:0] threshold;

  answer_t    pending_answers[$];
  int         mismatches;
  int         answers_checked;
  int         solved_seen;
  int         saturated_seen;
  int         idle_cycles;
  bit         timed_out;

  solve_3x3_cramer i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .problem   (problem),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .answer    (answer)
  );

  // Free-running clock with a period of 2.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Signed quotient rounded toward zero and clipped to the word range.
  function automatic word_t clipped_quotient(logic signed [255:0] num,
                                             logic signed [255:0] det,
                                             ref bit sat);
    logic signed [255:0] q;
    logic signed [255:0] max_w;
    logic signed [255:0] min_w;
    begin
      max_w = (256'sd1 <<< (DATA_WIDTH - 1)) - 1;
      min_w = -(256'sd1 <<< (DATA_WIDTH - 1));
      // SystemVerilog signed division truncates toward zero.
      q = (num <<< FRAC_BITS) / det;
      if (q > max_w) begin
        sat = 1'b1;
        q = max_w;
      end else if (q < min_w) begin
        sat = 1'b1;
        q = min_w;
      end
      return q[DATA_WIDTH-1:0];
    end
  endfunction

  // Expected answer for one system under the current threshold.
  function automatic answer_t solve_system(problem_t p);
    logic signed [255:0] m[9];
    logic signed [255:0] r[3];
    logic signed [255:0] det;
    logic signed [255:0] num[3];
    logic signed [255:0] abs_det;
    logic signed [255:0] bound;
    answer_t res;
    bit sat;
    begin
      m[0] = p.a_00; m[1] = p.a_01; m[2] = p.a_02;
      m[3] = p.a_10; m[4] = p.a_11; m[5] = p.a_12;
      m[6] = p.a_20; m[7] = p.a_21; m[8] = p.a_22;
      r[0] = p.rhs_0; r[1] = p.rhs_1; r[2] = p.rhs_2;
      det = m[0] * (m[4] * m[8] - m[5] * m[7])
          - m[1] * (m[3] * m[8] - m[5] * m[6])
          + m[2] * (m[3] * m[7] - m[4] * m[6]);
      num[0] = r[0] * (m[4] * m[8] - m[7] * m[5])
             + r[1] * (m[7] * m[2] - m[1] * m[8])
             + r[2] * (m[1] * m[5] - m[4] * m[2]);
      num[1] = r[0] * (m[6] * m[5] - m[3] * m[8])
             + r[1] * (m[0] * m[8] - m[2] * m[6])
             + r[2] * (m[2] * m[3] - m[0] * m[5]);
      num[2] = r[0] * (m[3] * m[7] - m[4] * m[6])
             + r[1] * (m[1] * m[6] - m[0] * m[7])
             + r[2] * (m[0] * m[4] - m[1] * m[3]);
      abs_det = (det < 0) ? -det : det;
      bound = $signed({225'd0, threshold}) <<< (2 * FRAC_BITS);
      res = '0;
      sat = 1'b0;
      if (abs_det > bound) begin
        res.sol_0 = clipped_quotient(num[0], det, sat);
        res.sol_1 = clipped_quotient(num[1], det, sat);
        res.sol_2 = clipped_quotient(num[2], det, sat);
        res.solved = 1'b1;
        res.saturated = sat;
      end
      return res;
    end
  endfunction

  // Random gap: mostly none or short, sometimes long.
  task automatic idle_gap();
    int n;
    begin
      n = $urandom_range(0, 99);
      if (n < 55) begin
        n = 0;
      end else if (n < 95) begin
        n = $urandom_range(1, 3);
      end else begin
        n = $urandom_range(10, 60);
      end
      if (n > 0) begin
        start <= 1'b0;
      end
      repeat (n) @(negedge clk);
    end
  endtask

  // Send one system as a single beat and record its expected answer.
  // Start stays high so that the next beat can follow without a gap.
  task automatic send_system(problem_t p);
    begin
      start <= 1'b1;
      problem <= p;
      @(posedge clk);
      while (busy) @(posedge clk);
      pending_answers.insert(pending_answers.size(), solve_system(p));
      @(negedge clk);
    end
  endtask

  // Wait for every expected answer, then let the pipeline drain.
  task automatic drain();
    begin
      start <= 1'b0;
      while (pending_answers.size() != 0 && !timed_out) @(negedge clk);
      repeat (LATENCY + 4) @(negedge clk);
    end
  endtask

  // Threshold writes happen only with the pipeline empty.
  task automatic write_threshold(logic [THR_WIDTH-1:0] value);
    begin
      drain();
      cfg_we <= 1'b1;
      cfg_wdata <= value;
      @(negedge clk);
      cfg_we <= 1'b0;
      threshold = value;
    end
  endtask

  function automatic word_t fx(int v);
    return word_t'(v);
  endfunction

  function automatic word_t rand_word();
    int k;
    begin
      k = $urandom_range(0, 9);
      if (k < 3) return word_t'($urandom());
      if (k < 7) return word_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      if (k < 8) return word_t'($signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200);
      return (k == 8) ? word_t'(32'h8000_0000) : word_t'(32'h7fff_ffff);
    end
  endfunction

  function automatic problem_t identity_system(word_t d, word_t r0, word_t r1, word_t r2);
    problem_t p;
    begin
      p = '0;
      p.a_00 = d; p.a_11 = d; p.a_22 = d;
      p.rhs_0 = r0; p.rhs_1 = r1; p.rhs_2 = r2;
      return p;
    end
  endfunction

  // Directed systems: identity, scaled, singular, tiny and extreme entries.
  task automatic test_directed();
    problem_t p;
    begin
      send_system(identity_system(fx(32'h0001_0000), fx(32'h0003_0000),
                                  fx(-32'sh0002_0000), fx(32'h0000_8000)));
      send_system(identity_system(fx(32'h0002_0000), fx(32'h7fff_ffff),
                                  fx(32'h8000_0000), fx(1)));
      // Tiny diagonal: the determinant is below the reset threshold, so not solvable.
      send_system(identity_system(fx(32'h0000_0100), fx(32'h7fff_ffff),
                                  fx(32'h8000_0000), fx(32'h0100_0000)));
      // Zero matrix: zero determinant is never solvable.
      send_system(identity_system(fx(0), fx(5), fx(6), fx(7)));
      p = '1;
      send_system(p);
      p = {12{32'h8000_0000}};
      send_system(p);
      p = {12{32'h7fff_ffff}};
      send_system(p);
      // Extreme entries on a nonsingular matrix.
      p = identity_system(fx(32'h8000_0000), fx(32'h7fff_ffff),
                          fx(32'h8000_0000), fx(32'h7fff_ffff));
      p.a_01 = fx(32'h7fff_ffff);
      send_system(p);
      p = identity_system(fx(32'h7fff_ffff), fx(-1), fx(1), fx(32'h8000_0000));
      p.a_20 = fx(32'h8000_0000);
      send_system(p);
      // Singular rows: row 2 equals row 0.
      p = identity_system(fx(32'h0001_0000), fx(1), fx(2), fx(3));
      p.a_20 = p.a_00; p.a_21 = p.a_01; p.a_22 = p.a_02;
      send_system(p);
      // Determinant of one and just above one, both above the reset threshold.
      send_system(identity_system(fx(32'h0001_0000), fx(9), fx(9), fx(9)));
      send_system(identity_system(fx(32'h0001_0001), fx(9), fx(-9), fx(9)));
      // Determinant below one but above the reset threshold: still solvable.
      send_system(identity_system(fx(32'h0000_8000), fx(9), fx(9), fx(9)));
    end
  endtask

  // Threshold extremes, including zero and the largest value.
  task automatic test_thresholds();
    begin
      write_threshold('0);
      send_system(identity_system(fx(32'h0000_0100), fx(1), fx(-1), fx(32'h10000)));
      send_system(identity_system(fx(0), fx(1), fx(1), fx(1)));
      send_system(identity_system(fx(1), fx(32'h7fff_ffff), fx(0), fx(-3)));
      write_threshold({THR_WIDTH{1'b1}});
      send_system(identity_system(fx(32'h7fff_ffff), fx(1), fx(2), fx(3)));
      send_system(identity_system(fx(32'h8000_0000), fx(1), fx(2), fx(3)));
      send_system(identity_system(fx(32'h0400_0000), fx(1), fx(2), fx(3)));
      write_threshold(31'd8);
      send_system(identity_system(fx(32'h0002_0000), fx(4), fx(5), fx(6)));
      send_system(identity_system(fx(32'h0002_0001), fx(4), fx(5), fx(6)));
    end
  endtask

  // Random systems under a series of thresholds, with random gaps.
  task automatic test_random();
    problem_t p;
    begin
      for (int i = 0; i < NUM_RANDOM; i++) begin
        if (i % 400 == 0) begin
          case ((i / 400) % 4)
            0: write_threshold(31'd0);
            1: write_threshold(31'd1);
            2: write_threshold(THR_WIDTH'($urandom()));
            default: write_threshold(THR_WIDTH'($urandom_range(0, 64)));
          endcase
        end else if (i % 250 == 0) begin
          drain();
        end
        p.a_00 = rand_word(); p.a_01 = rand_word(); p.a_02 = rand_word();
        p.a_10 = rand_word(); p.a_11 = rand_word(); p.a_12 = rand_word();
        p.a_20 = rand_word(); p.a_21 = rand_word(); p.a_22 = rand_word();
        p.rhs_0 = rand_word(); p.rhs_1 = rand_word(); p.rhs_2 = rand_word();
        // Every seventh system is made singular by a repeated column.
        if (i % 7 == 3) begin
          p.a_02 = p.a_00; p.a_12 = p.a_10; p.a_22 = p.a_20;
        end
        if (i % 200 < 60) begin
          send_system(p);
        end else begin
          idle_gap();
          send_system(p);
        end
      end
    end
  endtask

  // Check every result beat against the oldest expected answer.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", answer);
      end else begin
        answer_t exp_a;
        exp_a = pending_answers.pop_front();
        answers_checked++;
        if (answer.solved) solved_seen++;
        if (answer.saturated) saturated_seen++;
        if (answer.sol_0 !== exp_a.sol_0 || answer.sol_1 !== exp_a.sol_1 ||
            answer.sol_2 !== exp_a.sol_2 || answer.solved !== exp_a.solved ||
            answer.saturated !== exp_a.saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Answer mismatch: expected %h %h %h s=%b c=%b", exp_a.sol_0,
                     exp_a.sol_1, exp_a.sol_2, exp_a.solved, exp_a.saturated);
            $display("                 actual   %h %h %h s=%b c=%b", answer.sol_0,
                     answer.sol_1, answer.sol_2, answer.solved, answer.saturated);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    problem = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    threshold = 31'd1;
    mismatches = 0;
    answers_checked = 0;
    solved_seen = 0;
    saturated_seen = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_thresholds();
    test_random();
    drain();
    $display("Checked %0d answers: %0d solved, %0d saturated, %0d mismatches.",
             answers_checked, solved_seen, saturated_seen, mismatches);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

### solve_3x3_cramer.f
rtl/core/slv3_pkg.sv
rtl/core/solve_3x3_cramer.sv
verif/testbench.sv
